// ===== design/sss_pkg.sv =====
// Shared types and constants for the seven-segment scan shifter.
// Holds the word structs, mode codes, phase codes and the segment font.
// No dependencies.
package sss_pkg;

  localparam int DigitsDef = 4;
  localparam int BufDigits = 4;
  localparam int HoldW     = 16;

  typedef enum logic [1:0] {
    MODE_CLEAR      = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_WRITE_DOT  = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic       serial_data;
    logic       shift_strobe;
    logic       latch_level;
    logic [1:0] digit_index;
  } out_word_t;

  // Bit phase: 0..15 shift, then latch rise, then hold.
  localparam logic [4:0] PHASE_LATCH = 5'd16;
  localparam logic [4:0] PHASE_HOLD  = 5'd17;

  // Segments abcdefg. from bit 7 down to bit 0.
  function automatic logic [7:0] font_lookup(input logic [3:0] code);
    logic [7:0] pat;
    unique case (code)
      4'd0:    pat = 8'hFC;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hDA;
      4'd3:    pat = 8'hF2;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'hB6;
      4'd6:    pat = 8'hBE;
      4'd7:    pat = 8'hE0;
      4'd8:    pat = 8'hFE;
      4'd9:    pat = 8'hF6;
      4'd10:   pat = 8'h01;
      4'd11:   pat = 8'h00;
      4'd12:   pat = 8'h02;
      4'd13:   pat = 8'hEE;
      4'd14:   pat = 8'h3E;
      default: pat = 8'h9C;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/seven_segment_scan_shifter.sv =====
// Seven-segment scan shifter: buffer, scan sequencer and output register.
// Depends on sss_pkg for word types, mode codes and the font table.
// Serializes digit-select and segment bytes to a chained shift register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one word per item:
//   clear the buffer, write a character (optionally with its point), or a
//   scan tick. Every accepted word yields exactly one result word on the
//   output channel (out_valid / out_stall / out_word) with the data pin
//   level, shift strobe, latch level and the digit being scanned.
//   An accepted word's result is registered and shows from the next cycle
//   on. Throughput is one word per cycle while in_stall is low; the buffer
//   and scan state update and the result register loads in the same cycle.
//   The output register decouples the two sides: a new word is taken while
//   the previous result is leaving, and in_stall rises only while a result
//   is held and the receiver stalls.
//   cfg_we / cfg_wdata set the hold length (ticks the latch stays high after
//   each digit); write it only while idle.
//   Synchronous reset (rst_n low) blanks the buffer, restarts the scan at
//   digit zero with the latch low, clears the hold length and empties the
//   output register.
module seven_segment_scan_shifter #(
  parameter int DIGITS = sss_pkg::DigitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sss_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sss_pkg::out_word_t           out_word,
  input  logic                         cfg_we,
  input  logic [sss_pkg::HoldW-1:0]    cfg_wdata
);
  import sss_pkg::*;

  localparam int DigitW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [DigitW-1:0] LastDigit = DigitW'(DIGITS - 1);

  logic [HoldW-1:0]     hold_ticks_r;
  logic [8*BufDigits-1:0] seg_buf_r, seg_buf_nxt;
  logic [DigitW-1:0]    scan_digit_r, scan_digit_nxt;
  logic [4:0]           bit_phase_r, bit_phase_nxt;
  logic [HoldW-1:0]     hold_count_r, hold_count_nxt;
  logic                 latch_r, latch_nxt;
  logic                 out_valid_r;
  out_word_t            out_word_r, out_word_nxt;

  logic                 in_acc;
  logic [3:0]           dig_ext;
  logic [7:0]           seg_byte;
  logic [7:0]           font_pat;
  logic                 sel_bit;
  logic [HoldW-1:0]     hold_inc;
  logic [DigitW-1:0]    digit_inc;

  // Accept whenever the result slot is free or draining this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Current digit's segment byte; digits past the buffer read blank.
  assign dig_ext  = 4'(scan_digit_r);
  assign seg_byte = (dig_ext < 4'(BufDigits)) ? seg_buf_r[{dig_ext[1:0], 3'b000} +: 8] : 8'h00;
  // One-hot select byte: bit n is set when n matches the digit.
  assign sel_bit  = (bit_phase_r[2:0] == 3'(scan_digit_r));
  assign font_pat = font_lookup(in_word.char_code);
  assign hold_inc = hold_count_r + HoldW'(1);
  assign digit_inc = (scan_digit_r == LastDigit) ? '0 : scan_digit_r + DigitW'(1);

  always_comb begin
    seg_buf_nxt    = seg_buf_r;
    scan_digit_nxt = scan_digit_r;
    bit_phase_nxt  = bit_phase_r;
    hold_count_nxt = hold_count_r;
    latch_nxt      = latch_r;
    out_word_nxt.serial_data  = 1'b0;
    out_word_nxt.shift_strobe = 1'b0;

    unique case (in_word.mode)
      MODE_CLEAR: begin
        seg_buf_nxt = '0;
      end
      MODE_WRITE: begin
        seg_buf_nxt = {seg_buf_r[8*BufDigits-9:0], font_pat};
      end
      MODE_WRITE_DOT: begin
        seg_buf_nxt = {seg_buf_r[8*BufDigits-9:0], font_pat[7:1], 1'b1};
      end
      MODE_TICK: begin
        if (bit_phase_r < PHASE_LATCH) begin
          // Shift one bit: select byte first, then segment byte, LSB first.
          out_word_nxt.serial_data  = bit_phase_r[3] ? seg_byte[bit_phase_r[2:0]] : sel_bit;
          out_word_nxt.shift_strobe = 1'b1;
          latch_nxt     = 1'b0;
          bit_phase_nxt = bit_phase_r + 5'd1;
        end else if (bit_phase_r == PHASE_LATCH) begin
          latch_nxt      = 1'b1;
          hold_count_nxt = '0;
          if (hold_ticks_r == '0) begin
            scan_digit_nxt = digit_inc;
            bit_phase_nxt  = '0;
          end else begin
            bit_phase_nxt  = PHASE_HOLD;
          end
        end else begin
          // Hold the latch; a shortened hold length ends it on this tick.
          latch_nxt      = 1'b1;
          hold_count_nxt = hold_inc;
          if (hold_inc >= hold_ticks_r) begin
            scan_digit_nxt = digit_inc;
            bit_phase_nxt  = '0;
            hold_count_nxt = '0;
          end
        end
      end
      default: ;
    endcase

    out_word_nxt.latch_level = latch_nxt;
    out_word_nxt.digit_index = 2'(scan_digit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= '0;
      seg_buf_r    <= '0;
      scan_digit_r <= '0;
      bit_phase_r  <= '0;
      hold_count_r <= '0;
      latch_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        hold_ticks_r <= cfg_wdata;
      end
      if (in_acc) begin
        seg_buf_r    <= seg_buf_nxt;
        scan_digit_r <= scan_digit_nxt;
        bit_phase_r  <= bit_phase_nxt;
        hold_count_r <= hold_count_nxt;
        latch_r      <= latch_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Payload register: load on accept, otherwise hold.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_phase_r <= PHASE_HOLD)
    else $error("bit phase out of range");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_digit_r <= LastDigit)
    else $error("scan digit out of range");

  a_strobe_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.shift_strobe |-> !out_word_r.latch_level)
    else $error("latch high during a shift strobe");

  a_nontick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.mode != MODE_TICK |=>
      $stable(bit_phase_r) && $stable(scan_digit_r) && $stable(latch_r))
    else $error("scan advanced on a non-tick word");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule

// ===== dv/seven_segment_scan_checker.sv =====
// Checker for the seven-segment scan shifter: watches both channels and the hold register port.
// Predicts each result word from its own display and scan state and compares field by field.
// Depends on sss_pkg for the word structs, mode codes, phase codes and widths.
module seven_segment_scan_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  sss_pkg::in_word_t         in_word,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  sss_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [sss_pkg::HoldW-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  // Segments abcdefg. from bit 7 down to bit 0, indexed by character code.
  localparam logic [7:0] FONT_TABLE [16] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hF6, 8'h01, 8'h00, 8'h02, 8'hEE, 8'h3E, 8'h9C
  };

  logic [31:0]      seg_buf;
  logic [1:0]       cur_digit;
  logic [4:0]       phase;
  logic [HoldW-1:0] hold_cnt;
  logic [HoldW-1:0] hold_len;
  logic             latch_q;
  out_word_t        expected_pins [$];
  int               err_cnt;

  function automatic void move_to_next_digit();
    cur_digit = cur_digit + 2'd1;
    phase     = '0;
    hold_cnt  = '0;
  endfunction

  // Apply one input word to the display state and return the pin word it causes.
  function automatic out_word_t display_step(input in_word_t w);
    out_word_t  r;
    logic [7:0] pat;
    logic [7:0] src;
    r = '0;
    r.digit_index = cur_digit;
    case (w.mode)
      MODE_CLEAR: seg_buf = '0;
      MODE_WRITE, MODE_WRITE_DOT: begin
        pat = FONT_TABLE[w.char_code];
        if (w.mode == MODE_WRITE_DOT) pat[0] = 1'b1;
        seg_buf = {seg_buf[23:0], pat};
      end
      default: begin
        if (phase < PHASE_LATCH) begin
          // Select byte first, then the live segment byte, LSB first.
          src = phase[3] ? seg_buf[8*cur_digit +: 8] : (8'h01 << cur_digit);
          r.serial_data  = src[phase[2:0]];
          r.shift_strobe = 1'b1;
          latch_q        = 1'b0;
          phase          = phase + 5'd1;
        end else if (phase == PHASE_LATCH) begin
          latch_q  = 1'b1;
          hold_cnt = '0;
          if (hold_len == '0) move_to_next_digit();
          else phase = PHASE_HOLD;
        end else begin
          latch_q  = 1'b1;
          hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt >= hold_len) move_to_next_digit();
        end
      end
    endcase
    r.latch_level = latch_q;
    return r;
  endfunction

  function automatic void check_pin(input string name, input logic [1:0] want,
                                    input logic [1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  initial err_cnt = 0;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      seg_buf   = '0;
      cur_digit = '0;
      phase     = '0;
      hold_cnt  = '0;
      hold_len  = '0;
      latch_q   = 1'b0;
      expected_pins.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual %h", $time, out_word);
          err_cnt++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("serial_data", want.serial_data, out_word.serial_data);
          check_pin("shift_strobe", want.shift_strobe, out_word.shift_strobe);
          check_pin("latch_level", want.latch_level, out_word.latch_level);
          check_pin("digit_index", want.digit_index, out_word.digit_index);
        end
      end
      if (cfg_we) hold_len = cfg_wdata;
      if (in_valid && !in_stall) expected_pins.push_back(display_step(in_word));
    end
    errors  <= err_cnt;
    pending <= expected_pins.size();
  end

endmodule

// ===== dv/tb_seven_segment_scan_shifter.sv =====
// Top-level testbench for the seven-segment scan shifter: clock, reset, stimulus and verdict.
// Depends on sss_pkg, the block itself and seven_segment_scan_checker beside it.
module tb_seven_segment_scan_shifter;
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Receiver hold-off length and where it starts (in accepted result words).
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AT     = 150;
  localparam int RANDOM_ITEMS    = 1010;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [HoldW-1:0] cfg_wdata = '0;
  int               errors;
  int               pending;
  int               idle_cycles = 0;
  bit               sender_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_scan_shifter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  seven_segment_scan_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // Watchdog: reset the count on any accepted word, give up once it runs out.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_word_t word_of(input mode_t m, input logic [3:0] code);
    in_word_t w;
    w.mode      = m;
    w.char_code = code;
    return w;
  endfunction

  // Mostly scan ticks so the sequencer walks through shift, latch and hold;
  // writes and the odd clear land at random points of the scan.
  function automatic in_word_t rand_word();
    int    pick;
    mode_t m;
    pick = $urandom_range(99);
    if (pick < 3) m = MODE_CLEAR;
    else if (pick < 13) m = MODE_WRITE;
    else if (pick < 20) m = MODE_WRITE_DOT;
    else m = MODE_TICK;
    return word_of(m, 4'($urandom_range(15)));
  endfunction

  // Offer one word and return at the edge that accepts it. Called at an edge;
  // valid stays high straight into the next word unless a gap is drawn.
  task automatic send_word(input in_word_t w);
    int gap;
    if (!sender_quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      gap = 1;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(word_of(MODE_TICK, 4'($urandom_range(15))));
  endtask

  // Drop valid, drain every outstanding result, let the output register
  // settle, then write the hold length in one cycle.
  task automatic write_hold(input logic [HoldW-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps
  // offering (fills the output register and backs up the input), and a
  // quiet stretch with no stalls at all.
  initial begin : receiver
    int out_seen;
    int burst_left;
    bit burst_done;
    bit stall_next;
    out_seen   = 0;
    burst_left = 0;
    burst_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) out_seen++;
      if (burst_left > 0) begin
        burst_left--;
        stall_next = 1'b1;
      end else if (!burst_done && out_seen >= HOLD_OFF_AT) begin
        burst_done = 1'b1;
        burst_left = HOLD_OFF_CYCLES - 1;
        stall_next = 1'b1;
      end else if (out_seen >= 400 && out_seen < 600) begin
        stall_next = 1'b0;
      end else begin
        stall_next = ($urandom_range(99) < 12);
      end
      out_stall <= stall_next;
    end
  end

  initial begin : stimulus
    int i;
    // Hold reset, then release it at an edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Longest hold first so the latch sits high after digit 0.
    write_hold({HoldW{1'b1}});
    send_word(word_of(MODE_CLEAR, 4'd0));
    send_word(word_of(MODE_WRITE, 4'd0));
    send_word(word_of(MODE_WRITE_DOT, 4'd15));
    send_word(word_of(MODE_WRITE, 4'd10));
    send_word(word_of(MODE_WRITE, 4'd12));
    // Shift the select byte, then write mid-scan: the segment byte must
    // pick up the new character at once.
    send_ticks(8);
    send_word(word_of(MODE_WRITE, 4'd9));
    send_ticks(8);
    // Latch rise, then two hold ticks.
    send_ticks(3);
    // Lower the hold below the running count: the next tick ends the hold,
    // the one after starts digit 1 and drops the latch.
    write_hold(16'd1);
    send_ticks(2);
    // Zero hold: latch rise moves straight to the next digit.
    write_hold(16'd0);

    // Random part, in phases with different hold lengths.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) write_hold(16'd1);
      else if (i == 550) write_hold(16'($urandom_range(2, 6)));
      else if (i == 800) write_hold({HoldW{1'b1}});
      else if (i == 860) write_hold(16'd3);
      sender_quiet = (i >= 320 && i < 520);
      send_word(rand_word());
    end

    // Drain, let the last result leave the output register, give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
